// File: hw/rtl/tgarle_pkg.sv
// Shared types, register indexes and helper functions for the TGA RLE pixel decoder.
// No dependencies; used by every module of the block.
package tgarle_pkg;

  localparam logic [1:0] CFG_PIXEL_DEPTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [5:0] DEPTH_RESET = 6'd24;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic        overrun;
  } result_t;

  // Bytes per pixel from the bit depth, clamped to the range one to four.
  function automatic logic [2:0] bytes_per_pixel(input logic [5:0] depth);
    logic [6:0] sum;
    logic [3:0] b;
    sum = {1'b0, depth} + 7'd7;
    b   = sum[6:3];
    if (b == 4'd0) begin
      return 3'd1;
    end else if (b > 4'd4) begin
      return 3'd4;
    end
    return b[2:0];
  endfunction

endpackage

// File: hw/rtl/tgarle_decode.sv
// Packet decoder: header parsing, pixel byte gathering and image pixel countdown.
// Depends on tgarle_pkg for the result type and the bytes-per-pixel function.
module tgarle_decode
  import tgarle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  pixel_depth,
  input  logic [15:0] image_width,
  input  logic [15:0] image_height,
  output logic        emit,
  output result_t     result
);

  logic [31:0] pixels_left, pixels_left_next;
  logic        in_packet, in_packet_next;
  logic        is_run, is_run_next;
  logic [7:0]  packet_pixels_left, packet_pixels_left_next;
  logic [1:0]  byte_position, byte_position_next;
  logic [31:0] pixel_gather, pixel_gather_next;
  logic        image_active, image_active_next;
  logic        drain_mode, drain_mode_next;
  logic        emit_next;
  result_t     result_next;

  logic [2:0]  bpp;
  logic [31:0] area;

  assign bpp  = bytes_per_pixel(pixel_depth);
  assign area = 32'(image_width) * 32'(image_height);

  always_comb begin
    logic [1:0]  bp_inc;
    logic [31:0] gather_mix;
    logic [7:0]  rep;
    logic [31:0] pl;
    logic        over;
    logic        done;
    logic        skip;

    pixels_left_next        = pixels_left;
    in_packet_next          = in_packet;
    is_run_next             = is_run;
    packet_pixels_left_next = packet_pixels_left;
    byte_position_next      = byte_position;
    pixel_gather_next       = pixel_gather;
    image_active_next       = image_active;
    drain_mode_next         = drain_mode;
    emit_next               = 1'b0;
    result_next             = '0;
    bp_inc                  = byte_position + 2'd1;
    gather_mix              = pixel_gather | (32'(data_byte) << {byte_position, 3'b000});
    rep                     = 8'd1;
    pl                      = pixels_left;
    over                    = 1'b0;
    done                    = 1'b0;
    skip                    = 1'b0;

    if (!image_active) begin
      pl                = area;
      pixels_left_next  = area;
      if (image_width == 16'd0 || image_height == 16'd0) begin
        skip = 1'b1;
      end else begin
        image_active_next = 1'b1;
        in_packet_next    = 1'b0;
        drain_mode_next   = 1'b0;
      end
    end

    if (!skip) begin
      if (!image_active ? 1'b1 : !in_packet) begin
        is_run_next             = data_byte[7];
        packet_pixels_left_next = {1'b0, data_byte[6:0]} + 8'd1;
        in_packet_next          = 1'b1;
        byte_position_next      = 2'd0;
        pixel_gather_next       = '0;
      end else if (drain_mode) begin
        byte_position_next = bp_inc;
        if ({1'b0, bp_inc} >= bpp || bp_inc == 2'd0) begin
          byte_position_next      = 2'd0;
          packet_pixels_left_next = packet_pixels_left - 8'd1;
          if (packet_pixels_left == 8'd1) begin
            image_active_next       = 1'b0;
            in_packet_next          = 1'b0;
            drain_mode_next         = 1'b0;
            packet_pixels_left_next = '0;
            pixel_gather_next       = '0;
          end
        end
      end else if ({1'b0, byte_position} + 3'd1 < bpp) begin
        pixel_gather_next  = gather_mix;
        byte_position_next = bp_inc;
      end else begin
        if (is_run) begin
          rep = packet_pixels_left;
          if ({24'd0, packet_pixels_left} > pl) begin
            rep  = pl[7:0];
            over = 1'b1;
          end
          pl                      = pl - {24'd0, rep};
          packet_pixels_left_next = '0;
          in_packet_next          = 1'b0;
        end else begin
          rep                     = 8'd1;
          pl                      = pl - 32'd1;
          packet_pixels_left_next = packet_pixels_left - 8'd1;
          if (packet_pixels_left == 8'd1) begin
            in_packet_next = 1'b0;
          end else if (pl == 32'd0) begin
            over = 1'b1;
          end
        end
        done                     = (pl == 32'd0);
        pixels_left_next         = pl;
        emit_next                = 1'b1;
        result_next.pixel_value  = gather_mix;
        result_next.repeat_count = rep;
        result_next.image_done   = done;
        result_next.overrun      = over;
        byte_position_next       = 2'd0;
        pixel_gather_next        = '0;
        if (done) begin
          if (over && !is_run) begin
            drain_mode_next = 1'b1;
          end else begin
            image_active_next       = 1'b0;
            in_packet_next          = 1'b0;
            drain_mode_next         = 1'b0;
            packet_pixels_left_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_left        <= '0;
      in_packet          <= 1'b0;
      is_run             <= 1'b0;
      packet_pixels_left <= '0;
      byte_position      <= '0;
      pixel_gather       <= '0;
      image_active       <= 1'b0;
      drain_mode         <= 1'b0;
    end else if (step) begin
      pixels_left        <= pixels_left_next;
      in_packet          <= in_packet_next;
      is_run             <= is_run_next;
      packet_pixels_left <= packet_pixels_left_next;
      byte_position      <= byte_position_next;
      pixel_gather       <= pixel_gather_next;
      image_active       <= image_active_next;
      drain_mode         <= drain_mode_next;
    end
  end

  assign emit   = step && emit_next;
  assign result = result_next;

endmodule

// File: hw/rtl/tgarle_skid.sv
// Output register with a skid stage, so the input stall comes from a register, not from out_stall.
// Depends on tgarle_pkg for the result type.
module tgarle_skid
  import tgarle_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    out_free;

  assign out_free = !out_valid || !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// File: hw/rtl/tga_rle_pixel_decoder_core.sv
// Decodes a run-length coded TGA pixel stream one byte per transaction. Each byte is handled by the
// packet state update in the cycle it is accepted, so the block takes one byte every clock while
// in_stall is low; the result for a byte that completes a pixel goes to the output register, or to
// its skid stage while out_stall holds the output. A run packet gives one result with its repeat
// count, a raw packet one result per pixel. The input stalls only when both the output register
// and its skid stage hold results. The user must write configuration only while no transaction is
// in flight; the block does not enforce it. Depends on tgarle_pkg, tgarle_decode and tgarle_skid.
module tga_rle_pixel_decoder_core
  import tgarle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pixel_value,
  output logic [7:0]  repeat_count,
  output logic        image_done,
  output logic        overrun
);

  logic [5:0]  pixel_depth;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        step;
  logic        emit;
  logic        full;
  result_t     result;
  result_t     out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_depth  <= DEPTH_RESET;
      image_width  <= '0;
      image_height <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PIXEL_DEPTH:  pixel_depth  <= cfg_data[5:0];
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = full;
  assign step     = in_valid && !full;

  tgarle_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .data_byte    (data_byte),
    .pixel_depth  (pixel_depth),
    .image_width  (image_width),
    .image_height (image_height),
    .emit         (emit),
    .result       (result)
  );

  tgarle_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign pixel_value  = out_data.pixel_value;
  assign repeat_count = out_data.repeat_count;
  assign image_done   = out_data.image_done;
  assign overrun      = out_data.overrun;

endmodule
